/* src/tbjp_pkg.sv */
package tbjp_pkg;

  localparam int PLANE_DIM  = 256;
  localparam int COORD_W    = $clog2(PLANE_DIM);
  localparam int PIX_ADDR_W = 2 * COORD_W;
  localparam int FRAC_BITS  = 16;
  localparam int MAX_RADIUS = 7;
  localparam int COUNT_W    = 17;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_DRAW  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  localparam logic [1:0] REG_STAMP_RADIUS = 2'd0;
  localparam logic [1:0] REG_PLANE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_PLANE_WIDTH  = 2'd2;

  typedef struct packed {
    op_t                op;
    logic [7:0]         start_row;
    logic [7:0]         start_col;
    logic signed [15:0] start_tan_row;
    logic signed [15:0] start_tan_col;
    logic [7:0]         end_row;
    logic [7:0]         end_col;
    logic signed [15:0] end_tan_row;
    logic signed [15:0] end_tan_col;
    logic [1:0]         pixel_bits;
  } cmd_t;

  typedef struct packed {
    logic [2:0] radius;
    logic [8:0] height;
    logic [8:0] width;
  } cfg_t;

endpackage

/* src/tbjp_front.sv */
module tbjp_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  logic [1:0]    opcode,
  input  tbjp_pkg::cmd_t raw_cmd,
  output logic          cmd_valid,
  output tbjp_pkg::cmd_t cmd,
  input  logic          cmd_take
);
  import tbjp_pkg::*;

  cmd_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;
  cmd_t       cls;

  // classify: decode the opcode into the command type
  always_comb begin
    cls = raw_cmd;
    case (opcode)
      2'd0:    cls.op = OP_WRITE;
      2'd1:    cls.op = OP_READ;
      2'd2:    cls.op = OP_DRAW;
      default: cls.op = OP_NOP;
    endcase
  end

  assign full      = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (do_push) q_r[wp_r] <= cls;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= !wp_r;
      if (do_pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

/* src/tbjp_div.sv */
module tbjp_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [27:0] dividend,
  input  logic [9:0]  divisor,
  output logic        done,
  output logic [27:0] quot,
  output logic [9:0]  rem
);
  import tbjp_pkg::*;

  logic [27:0] q_r;
  logic [9:0]  r_r, dvs_r;
  logic [4:0]  cnt_r;
  logic        busy_r, done_r;
  logic [10:0] trial, diff;
  logic        ge;

  // restoring divide, one quotient bit a cycle
  always_comb begin
    trial = {r_r, q_r[27]};
    ge    = trial >= {1'b0, dvs_r};
    diff  = trial - {1'b0, dvs_r};
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = r_r;

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      r_r   <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      q_r <= {q_r[26:0], ge};
      r_r <= ge ? diff[9:0] : trial[9:0];
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd27) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

/* src/tbjp_back.sv */
module tbjp_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  input  tbjp_pkg::cmd_t cmd,
  output logic           cmd_take,
  input  tbjp_pkg::cfg_t cfg,
  output logic           res_empty,
  input  logic           res_pop,
  output logic [16:0]    res_count,
  output logic           res_fg,
  output logic           res_marked
);
  import tbjp_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_RD    = 12'b000000000010,
    S_CHK   = 12'b000000000100,
    S_SQRT  = 12'b000000001000,
    S_HMUL  = 12'b000000010000,
    S_HDIV  = 12'b000000100000,
    S_SDIV  = 12'b000001000000,
    S_SMUL  = 12'b000010000000,
    S_ROUND = 12'b000100000000,
    S_DISC  = 12'b001000000000,
    S_DISCW = 12'b010000000000,
    S_DONE  = 12'b100000000000
  } st_t;

  function automatic logic signed [49:0] trunc_frac(input logic signed [49:0] v);
    logic [49:0] m;
    m = v[49] ? 50'(-v) : 50'(v);
    m = m >> FRAC_BITS;
    return v[49] ? -$signed(m) : $signed(m);
  endfunction

  st_t state_r, state_nxt;
  cmd_t cmd_r;

  // pixel store: bit0 foreground, bit1 painted
  logic [1:0] mem [PLANE_DIM * PLANE_DIM];
  logic [1:0] rdata_r;
  logic       mem_we, mem_re;
  logic [PIX_ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [1:0] mem_wdata;

  logic [16:0] d2_r;
  logic [33:0] sv_r;
  logic [18:0] rem_r;
  logic [16:0] root_r, dist8_r;
  logic [4:0]  it_r;
  logic [9:0]  steps_r;
  logic [1:0]  h_r;
  logic        ph_r;
  logic signed [27:0] py_r [4];
  logic signed [27:0] px_r [4];
  logic [16:0] qstep_r;
  logic [9:0]  rstep_r, tr_r, s_r;
  logic [16:0] t_r, uu_r, tt_r;
  logic [16:0] b_r [4];
  logic [3:0]  k_r;
  logic signed [49:0] accy_r, accx_r;
  logic signed [11:0] iy_r, ix_r;
  logic signed [3:0]  ry_r, rx_r;
  logic [16:0] cnt_r;
  logic        fgq_r, mkq_r;
  logic        out_valid_r, out_fg_r, out_mk_r;
  logic [16:0] out_cnt_r;
  logic [24:0] q3_r;

  logic signed [27:0] mul_a;
  logic signed [19:0] mul_b;
  logic signed [47:0] prod_r;

  logic        div_start, div_done;
  logic [27:0] div_dividend, div_quot;
  logic [9:0]  div_divisor, div_rem;

  logic signed [8:0]  dr, dc;
  logic signed [17:0] dr2, dc2;
  logic [17:0] d2sum;
  logic [20:0] remsh, sq_trial, sq_diff;
  logic        sq_ge;
  logic [18:0] rem_nxt;
  logic [16:0] root_nxt;
  logic [16:0] u_w;
  logic [18:0] uu3, u3;
  logic signed [15:0] tan_sel;
  logic [16:0] tabs;
  logic signed [27:0] off;
  logic [51:0] q3_prod;
  logic [1:0]  pidx;
  logic [10:0] tr_sum;
  logic signed [49:0] qy, qx, iy_full, ix_full;
  logic signed [3:0]  rad_s;
  logic signed [7:0]  ryw, rxw;
  logic [7:0]  dsq, r2;
  logic signed [12:0] ny, nx;
  logic [8:0]  hgt, wid;
  logic        pix_ok, row_last, col_last, last_sample;
  logic        out_load;

  tbjp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_comb begin
    dr    = $signed({1'b0, cmd.end_row}) - $signed({1'b0, cmd.start_row});
    dc    = $signed({1'b0, cmd.end_col}) - $signed({1'b0, cmd.start_col});
    dr2   = dr * dr;
    dc2   = dc * dc;
    d2sum = $unsigned(dr2) + $unsigned(dc2);

    // square root, two radicand bits a step
    remsh    = {rem_r, sv_r[33:32]};
    sq_trial = {2'b0, root_r, 2'b01};
    sq_ge    = remsh >= sq_trial;
    sq_diff  = remsh - sq_trial;
    rem_nxt  = sq_ge ? sq_diff[18:0] : remsh[18:0];
    root_nxt = {root_r[15:0], sq_ge};

    u_w  = 17'h10000 - t_r;
    uu3  = {2'b0, uu_r} + {1'b0, uu_r, 1'b0};
    u3   = {2'b0, u_w} + {1'b0, u_w, 1'b0};
    pidx = k_r[1:0] - 2'd2;

    case (h_r)
      2'd0:    tan_sel = cmd_r.start_tan_row;
      2'd1:    tan_sel = cmd_r.start_tan_col;
      2'd2:    tan_sel = cmd_r.end_tan_row;
      default: tan_sel = cmd_r.end_tan_col;
    endcase
    tabs = tan_sel[15] ? 17'(-$signed({tan_sel[15], tan_sel})) : {1'b0, tan_sel};
    // divide by 3 as a multiply by ceil(2^27/3), exact for dividends below 2^27
    q3_prod = {26'b0, prod_r[31:6]} * {26'b0, 26'h2AAAAAB};
    off  = tan_sel[15] ? -$signed({3'b0, q3_r}) : $signed({3'b0, q3_r});

    mul_a = '0;
    mul_b = '0;
    if (state_r == S_HMUL) begin
      mul_a = $signed({11'b0, tabs});
      mul_b = $signed({3'b0, dist8_r});
    end else if (state_r == S_SMUL) begin
      case (k_r)
        4'd0: begin mul_a = $signed({11'b0, u_w});  mul_b = $signed({3'b0, u_w}); end
        4'd1: begin mul_a = $signed({11'b0, t_r});  mul_b = $signed({3'b0, t_r}); end
        4'd2: begin mul_a = $signed({11'b0, uu_r}); mul_b = $signed({3'b0, u_w}); end
        4'd3: begin mul_a = $signed({9'b0, uu3});   mul_b = $signed({3'b0, t_r}); end
        4'd4: begin mul_a = $signed({9'b0, u3});    mul_b = $signed({3'b0, tt_r}); end
        4'd5: begin mul_a = $signed({11'b0, tt_r}); mul_b = $signed({3'b0, t_r}); end
        4'd6, 4'd7, 4'd8, 4'd9: begin
          mul_a = py_r[pidx];
          mul_b = $signed({3'b0, b_r[pidx]});
        end
        default: begin
          mul_a = px_r[pidx];
          mul_b = $signed({3'b0, b_r[pidx]});
        end
      endcase
    end

    tr_sum = {1'b0, tr_r} + {1'b0, rstep_r};

    qy      = trunc_frac(accy_r);
    qx      = trunc_frac(accx_r);
    iy_full = trunc_frac(qy + 50'sd32768);
    ix_full = trunc_frac(qx + 50'sd32768);

    rad_s = $signed({1'b0, cfg.radius});
    ryw   = $signed({{4{ry_r[3]}}, ry_r});
    rxw   = $signed({{4{rx_r[3]}}, rx_r});
    dsq   = 8'(ryw * ryw) + 8'(rxw * rxw);
    r2    = {5'b0, cfg.radius} * {5'b0, cfg.radius};
    hgt   = (cfg.height > 9'd256) ? 9'd256 : cfg.height;
    wid   = (cfg.width  > 9'd256) ? 9'd256 : cfg.width;
    ny    = $signed({iy_r[11], iy_r}) + $signed({{9{ry_r[3]}}, ry_r});
    nx    = $signed({ix_r[11], ix_r}) + $signed({{9{rx_r[3]}}, rx_r});
    pix_ok = (dsq <= r2) && !ny[12] && !nx[12]
             && ($unsigned(ny) < {4'b0, hgt}) && ($unsigned(nx) < {4'b0, wid});
    col_last    = (rx_r == rad_s);
    row_last    = (ry_r == rad_s);
    last_sample = (s_r == steps_r);
  end

  assign cmd_take = (state_r == S_IDLE) && cmd_valid;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || res_pop);

  always_comb begin
    mem_we       = 1'b0;
    mem_waddr    = {cmd.start_row, cmd.start_col};
    mem_wdata    = cmd.pixel_bits;
    mem_re       = 1'b0;
    mem_raddr    = {cmd.start_row, cmd.start_col};
    div_start    = 1'b0;
    div_dividend = 28'h10000;
    div_divisor  = steps_r;
    if (state_r == S_IDLE && cmd_valid) begin
      mem_we = (cmd.op == OP_WRITE);
      mem_re = (cmd.op == OP_READ);
    end
    if (state_r == S_DISC && pix_ok) begin
      mem_re    = 1'b1;
      mem_raddr = {ny[7:0], nx[7:0]};
    end
    if (state_r == S_DISCW) begin
      mem_waddr = {ny[7:0], nx[7:0]};
      mem_wdata = 2'b11;
      mem_we    = !rdata_r[0];
    end
    if (state_r == S_SDIV && !ph_r) div_start = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_r <= mem[mem_raddr];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            OP_READ: state_nxt = S_RD;
            OP_DRAW: state_nxt = S_CHK;
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_RD:    state_nxt = S_DONE;
      S_CHK:   state_nxt = (d2_r == '0) ? S_DONE : S_SQRT;
      S_SQRT:  if (it_r == 5'd16) state_nxt = S_HMUL;
      S_HMUL:  state_nxt = S_HDIV;
      S_HDIV:  if (ph_r) state_nxt = (h_r == 2'd3) ? S_SDIV : S_HMUL;
      S_SDIV:  if (ph_r && div_done) state_nxt = S_SMUL;
      S_SMUL:  if (ph_r && k_r == 4'd13) state_nxt = S_ROUND;
      S_ROUND: state_nxt = S_DISC;
      S_DISC, S_DISCW: begin
        if (state_r == S_DISC && pix_ok) state_nxt = S_DISCW;
        else if (col_last && row_last) state_nxt = last_sample ? S_DONE : S_SMUL;
        else state_nxt = S_DISC;
      end
      S_DONE:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (state_r)
      S_IDLE: begin
        cmd_r <= cmd;
        d2_r  <= d2sum[16:0];
        cnt_r <= '0;
        fgq_r <= 1'b0;
        mkq_r <= 1'b0;
      end
      S_RD: begin
        fgq_r <= rdata_r[0];
        mkq_r <= rdata_r[1];
      end
      S_CHK: begin
        sv_r   <= {1'b0, d2_r, 16'b0};
        rem_r  <= '0;
        root_r <= '0;
        it_r   <= '0;
      end
      S_SQRT: begin
        sv_r   <= {sv_r[31:0], 2'b00};
        rem_r  <= rem_nxt;
        root_r <= root_nxt;
        it_r   <= it_r + 5'd1;
        if (it_r == 5'd16) begin
          dist8_r <= root_nxt;
          steps_r <= root_nxt[16:7] + 10'd1;
          py_r[0] <= $signed({4'b0, cmd_r.start_row, 16'b0});
          px_r[0] <= $signed({4'b0, cmd_r.start_col, 16'b0});
          py_r[3] <= $signed({4'b0, cmd_r.end_row, 16'b0});
          px_r[3] <= $signed({4'b0, cmd_r.end_col, 16'b0});
          h_r     <= '0;
        end
      end
      S_HMUL: ph_r <= 1'b0;
      S_HDIV: begin
        if (!ph_r) begin
          ph_r <= 1'b1;
          q3_r <= q3_prod[51:27];
        end else begin
          ph_r <= 1'b0;
          h_r  <= h_r + 2'd1;
          case (h_r)
            2'd0:    py_r[1] <= py_r[0] + off;
            2'd1:    px_r[1] <= px_r[0] + off;
            2'd2:    py_r[2] <= py_r[3] + off;
            default: px_r[2] <= px_r[3] + off;
          endcase
        end
      end
      S_SDIV: begin
        if (!ph_r) ph_r <= 1'b1;
        else if (div_done) begin
          ph_r    <= 1'b0;
          qstep_r <= div_quot[16:0];
          rstep_r <= div_rem;
          s_r     <= '0;
          t_r     <= '0;
          tr_r    <= '0;
          k_r     <= '0;
        end
      end
      S_SMUL: begin
        ph_r <= !ph_r;
        if (ph_r) begin
          k_r <= k_r + 4'd1;
          case (k_r)
            4'd0:    uu_r   <= prod_r[32:16];
            4'd1:    tt_r   <= prod_r[32:16];
            4'd2:    b_r[0] <= prod_r[32:16];
            4'd3:    b_r[1] <= prod_r[32:16];
            4'd4:    b_r[2] <= prod_r[32:16];
            4'd5:    b_r[3] <= prod_r[32:16];
            4'd6:    accy_r <= 50'(prod_r);
            4'd7, 4'd8, 4'd9: accy_r <= accy_r + 50'(prod_r);
            4'd10:   accx_r <= 50'(prod_r);
            default: accx_r <= accx_r + 50'(prod_r);
          endcase
        end
      end
      S_ROUND: begin
        iy_r <= iy_full[11:0];
        ix_r <= ix_full[11:0];
        ry_r <= -rad_s;
        rx_r <= -rad_s;
      end
      S_DISC, S_DISCW: begin
        if (state_r == S_DISCW && !rdata_r[0] && cnt_r != {COUNT_W{1'b1}})
          cnt_r <= cnt_r + 17'd1;
        if (!(state_r == S_DISC && pix_ok)) begin
          if (!col_last) rx_r <= rx_r + 4'sd1;
          else begin
            rx_r <= -rad_s;
            if (!row_last) ry_r <= ry_r + 4'sd1;
            else begin
              // next curve sample: t advances by steps-th of one
              s_r  <= s_r + 10'd1;
              k_r  <= '0;
              ph_r <= 1'b0;
              if (tr_sum >= {1'b0, steps_r}) begin
                tr_r <= 10'(tr_sum - {1'b0, steps_r});
                t_r  <= t_r + qstep_r + 17'd1;
              end else begin
                tr_r <= tr_sum[9:0];
                t_r  <= t_r + qstep_r;
              end
            end
          end
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_cnt_r <= cnt_r;
      out_fg_r  <= fgq_r;
      out_mk_r  <= mkq_r;
    end
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (res_pop) out_valid_r <= 1'b0;
    end
  end

  assign res_empty  = !out_valid_r;
  assign res_count  = out_cnt_r;
  assign res_fg     = out_fg_r;
  assign res_marked = out_mk_r;

endmodule

/* src/thick_bezier_join_painter.sv */
// Thick cubic Bezier join painter.
// Input queue: drive the fields and push while full is low; one beat per command.
// Opcode 0 loads one pixel (fg, painted), 1 reads one back, 2 draws a curve
// between two endpoints with Q1.14 tangents and stamps a disc at each sample.
// Result queue: while empty is low the oldest result is on the out_ ports;
// pop takes it. Every command gives exactly one result beat.
// A draw runs the square root, the handle offsets and the step divide, then
// per curve sample a run of the shared multiplier and a walk over the disc
// positions, with a write step for each one in the disc and the plane;
// samples = floor(2*dist)+2. The back end runs one command at a time; a
// two-entry command queue and a one-entry result register decouple it from
// both sides. If pop stays low the back end holds its finished result, then
// the command queue fills and full rises. Reset clears the queues and loads
// the config registers (radius 1, 256 x 256); the pixel store is not cleared
// and must be written by the host before it is read or drawn over.
// Configuration: cfg_we writes cfg_data to register cfg_index; the host must
// do so only while idle, which the block itself does not enforce.
module thick_bezier_join_painter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_start_row,
  input  logic [7:0]  in_start_col,
  input  logic signed [15:0] in_start_tan_row,
  input  logic signed [15:0] in_start_tan_col,
  input  logic [7:0]  in_end_row,
  input  logic [7:0]  in_end_col,
  input  logic signed [15:0] in_end_tan_row,
  input  logic signed [15:0] in_end_tan_col,
  input  logic [1:0]  in_pixel_bits,
  output logic        empty,
  input  logic        pop,
  output logic [16:0] out_added_count,
  output logic        out_pixel_fg,
  output logic        out_pixel_marked,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);
  import tbjp_pkg::*;

  cfg_t cfg_r;
  cmd_t raw_cmd, cmd;
  logic cmd_valid, cmd_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.radius <= 3'd1;
      cfg_r.height <= 9'd256;
      cfg_r.width  <= 9'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STAMP_RADIUS: cfg_r.radius <= cfg_data[2:0];
        REG_PLANE_HEIGHT: cfg_r.height <= cfg_data;
        REG_PLANE_WIDTH:  cfg_r.width  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    raw_cmd.op            = OP_NOP;
    raw_cmd.start_row     = in_start_row;
    raw_cmd.start_col     = in_start_col;
    raw_cmd.start_tan_row = in_start_tan_row;
    raw_cmd.start_tan_col = in_start_tan_col;
    raw_cmd.end_row       = in_end_row;
    raw_cmd.end_col       = in_end_col;
    raw_cmd.end_tan_row   = in_end_tan_row;
    raw_cmd.end_tan_col   = in_end_tan_col;
    raw_cmd.pixel_bits    = in_pixel_bits;
  end

  tbjp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .opcode    (in_opcode),
    .raw_cmd   (raw_cmd),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  tbjp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_take   (cmd_take),
    .cfg        (cfg_r),
    .res_empty  (empty),
    .res_pop    (pop),
    .res_count  (out_added_count),
    .res_fg     (out_pixel_fg),
    .res_marked (out_pixel_marked)
  );

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import tbjp_pkg::*;

  typedef struct packed {
    logic [16:0] count;
    logic        fg;
    logic        marked;
  } res_t;

  typedef struct {
    cmd_t c;
    bit   known;
    res_t r;
  } row_t;

  localparam longint CYCLE_LIMIT = 20_000_000;
  localparam int     STALL_LEN   = 500;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               push = 0;
  logic               full;
  logic [1:0]         in_opcode = '0;
  logic [7:0]         in_start_row = '0;
  logic [7:0]         in_start_col = '0;
  logic signed [15:0] in_start_tan_row = '0;
  logic signed [15:0] in_start_tan_col = '0;
  logic [7:0]         in_end_row = '0;
  logic [7:0]         in_end_col = '0;
  logic signed [15:0] in_end_tan_row = '0;
  logic signed [15:0] in_end_tan_col = '0;
  logic [1:0]         in_pixel_bits = '0;
  logic               empty;
  logic               pop = 0;
  logic [16:0]        out_added_count;
  logic               out_pixel_fg;
  logic               out_pixel_marked;
  logic               cfg_we = 0;
  logic [1:0]         cfg_index = '0;
  logic [8:0]         cfg_data = '0;

  thick_bezier_join_painter dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_opcode(in_opcode), .in_start_row(in_start_row), .in_start_col(in_start_col),
    .in_start_tan_row(in_start_tan_row), .in_start_tan_col(in_start_tan_col),
    .in_end_row(in_end_row), .in_end_col(in_end_col),
    .in_end_tan_row(in_end_tan_row), .in_end_tan_col(in_end_tan_col),
    .in_pixel_bits(in_pixel_bits), .empty(empty), .pop(pop),
    .out_added_count(out_added_count), .out_pixel_fg(out_pixel_fg),
    .out_pixel_marked(out_pixel_marked),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // shadow of the pixel store and registers
  bit         fg_shadow [PLANE_DIM*PLANE_DIM];
  bit         mark_shadow [PLANE_DIM*PLANE_DIM];
  bit         loaded [PLANE_DIM*PLANE_DIM];
  int         loaded_list [$];
  logic [2:0] radius_q = 3'd1;
  logic [8:0] height_q = 9'd256;
  logic [8:0] width_q = 9'd256;

  res_t   pending_q [$];
  int     errs = 0;
  int     n_cmds = 0, n_draws = 0, n_reads = 0, n_cfg = 0;
  bit     eager = 0;
  int     stall_asks = 0, stall_done = 0, hold = 0;
  longint cyc = 0;

  function automatic longint unsigned sqrt_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'h1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint handle_len(longint unsigned d8, longint tn);
    longint unsigned mag, q;
    mag = longint'(tn < 0 ? -tn : tn) * d8;
    q = (mag << FRAC_BITS) / (64'd3 << 22);
    return tn < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint shr_trunc(longint v);
    if (v < 0) return -((-v) >>> FRAC_BITS);
    return v >>> FRAC_BITS;
  endfunction

  function automatic logic [16:0] paint_curve(cmd_t c);
    longint r0, c0, r3, c3, d2, rad, h, w, iy, ix, qy, qx, ny, nx, one;
    longint b0, b1, b2, b3;
    longint py [4], px [4];
    longint unsigned d8, steps, t, u, tt, uu;
    int added, pos;
    r0 = longint'(c.start_row); c0 = longint'(c.start_col);
    r3 = longint'(c.end_row);   c3 = longint'(c.end_col);
    d2 = (r3 - r0) * (r3 - r0) + (c3 - c0) * (c3 - c0);
    if (d2 == 0) return '0;
    one = 64'sd1 <<< FRAC_BITS;
    d8 = sqrt_floor(longint'(d2) << 16);
    steps = sqrt_floor(4 * d2) + 1;
    py[0] = r0 * one; px[0] = c0 * one;
    py[3] = r3 * one; px[3] = c3 * one;
    py[1] = py[0] + handle_len(d8, longint'(c.start_tan_row));
    px[1] = px[0] + handle_len(d8, longint'(c.start_tan_col));
    py[2] = py[3] + handle_len(d8, longint'(c.end_tan_row));
    px[2] = px[3] + handle_len(d8, longint'(c.end_tan_col));
    rad = (radius_q > MAX_RADIUS) ? longint'(MAX_RADIUS) : longint'(radius_q);
    h = (height_q > PLANE_DIM) ? longint'(PLANE_DIM) : longint'(height_q);
    w = (width_q > PLANE_DIM) ? longint'(PLANE_DIM) : longint'(width_q);
    added = 0;
    for (longint unsigned s = 0; s <= steps; s++) begin
      t = (s << FRAC_BITS) / steps;
      u = (64'd1 << FRAC_BITS) - t;
      tt = (t * t) >> FRAC_BITS;
      uu = (u * u) >> FRAC_BITS;
      b0 = (uu * u) >> FRAC_BITS;
      b1 = (3 * uu * t) >> FRAC_BITS;
      b2 = (3 * u * tt) >> FRAC_BITS;
      b3 = (tt * t) >> FRAC_BITS;
      qy = shr_trunc(b0 * py[0] + b1 * py[1] + b2 * py[2] + b3 * py[3]);
      qx = shr_trunc(b0 * px[0] + b1 * px[1] + b2 * px[2] + b3 * px[3]);
      iy = shr_trunc(qy + (one >>> 1));
      ix = shr_trunc(qx + (one >>> 1));
      for (longint ry = -rad; ry <= rad; ry++)
        for (longint rx = -rad; rx <= rad; rx++) begin
          ny = iy + ry;
          nx = ix + rx;
          if (ry * ry + rx * rx <= rad * rad && ny >= 0 && ny < h && nx >= 0 && nx < w) begin
            pos = int'(ny * PLANE_DIM + nx);
            if (!fg_shadow[pos]) begin
              fg_shadow[pos] = 1;
              mark_shadow[pos] = 1;
              if (added < 131071) added++;
            end
          end
        end
    end
    return added[16:0];
  endfunction

  function automatic res_t predict(cmd_t c);
    res_t r;
    int pos;
    r = '0;
    pos = int'(c.start_row) * PLANE_DIM + int'(c.start_col);
    case (c.op)
      OP_WRITE: begin
        fg_shadow[pos] = c.pixel_bits[0];
        mark_shadow[pos] = c.pixel_bits[1];
      end
      OP_READ: begin
        r.fg = fg_shadow[pos];
        r.marked = mark_shadow[pos];
      end
      OP_DRAW: r.count = paint_curve(c);
      default: ;
    endcase
    return r;
  endfunction

  function automatic void note_loaded(int row, int col);
    int pos;
    pos = row * PLANE_DIM + col;
    if (!loaded[pos]) begin
      loaded[pos] = 1;
      loaded_list.push_back(pos);
    end
  endfunction

  function automatic cmd_t mk(op_t op, int sr, int sc, int str, int stc,
                              int er, int ec, int etr, int etc, int pb);
    cmd_t c;
    c.op = op;
    c.start_row = 8'(sr); c.start_col = 8'(sc);
    c.start_tan_row = 16'(str); c.start_tan_col = 16'(stc);
    c.end_row = 8'(er); c.end_col = 8'(ec);
    c.end_tan_row = 16'(etr); c.end_tan_col = 16'(etc);
    c.pixel_bits = 2'(pb);
    return c;
  endfunction

  function automatic res_t rz(int cnt, bit fg, bit mk_bit);
    res_t r;
    r.count = 17'(cnt);
    r.fg = fg;
    r.marked = mk_bit;
    return r;
  endfunction

  function automatic logic signed [15:0] pick_tan();
    int k;
    k = $urandom_range(0, 9);
    if (k < 5) return 16'($urandom_range(0, 32768) - 16384);
    if (k < 7) return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
    if (k < 8) return '0;
    return 16'($urandom);
  endfunction

  function automatic cmd_t gen_cmd(int span);
    cmd_t c;
    int k, pos, sp;
    logic [127:0] rbits;
    rbits = {$urandom, $urandom, $urandom, $urandom};
    c = rbits[$bits(cmd_t)-1:0];
    k = $urandom_range(0, 99);
    if (k < 30) begin
      c.op = OP_WRITE;
      if (span < 255 && $urandom_range(0, 9) < 7) begin
        c.start_row = 8'($urandom_range(0, span));
        c.start_col = 8'($urandom_range(0, span));
      end
      if ($urandom_range(0, 3) != 0) c.pixel_bits[0] = 1'b0;
      note_loaded(int'(c.start_row), int'(c.start_col));
    end else if (k < 60) begin
      c.op = OP_READ;
      pos = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
      c.start_row = 8'(pos / PLANE_DIM);
      c.start_col = 8'(pos % PLANE_DIM);
    end else if (k < 88) begin
      c.op = OP_DRAW;
      sp = (span == 255 && $urandom_range(0, 4) != 0) ? 27 : span;
      c.start_row = 8'($urandom_range(0, sp));
      c.start_col = 8'($urandom_range(0, sp));
      c.end_row = 8'($urandom_range(0, sp));
      c.end_col = 8'($urandom_range(0, sp));
      c.start_tan_row = pick_tan(); c.start_tan_col = pick_tan();
      c.end_tan_row = pick_tan();   c.end_tan_col = pick_tan();
    end else begin
      c.op = OP_NOP;
    end
    return c;
  endfunction

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 19);
    if (k < 9) return 0;
    if (k < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_cmd(cmd_t c, bit known, res_t kv);
    int gap;
    bit ok;
    res_t r;
    gap = eager ? 0 : pick_gap();
    if (gap > 0) begin
      push <= 0;
      repeat (gap) @(posedge clk);
    end
    push <= 1;
    in_opcode <= c.op;
    in_start_row <= c.start_row;       in_start_col <= c.start_col;
    in_start_tan_row <= c.start_tan_row; in_start_tan_col <= c.start_tan_col;
    in_end_row <= c.end_row;           in_end_col <= c.end_col;
    in_end_tan_row <= c.end_tan_row;   in_end_tan_col <= c.end_tan_col;
    in_pixel_bits <= c.pixel_bits;
    do begin
      @(negedge clk);
      ok = !full;
      @(posedge clk);
    end while (!ok);
    r = predict(c);
    if (known) r = kv;
    pending_q.push_back(r);
    n_cmds++;
    if (c.op == OP_DRAW) n_draws++;
    if (c.op == OP_READ) n_reads++;
  endtask

  task automatic drain();
    push <= 0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic cfg_set(logic [1:0] idx, logic [8:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
    case (idx)
      REG_STAMP_RADIUS: radius_q = v[2:0];
      REG_PLANE_HEIGHT: height_q = v;
      REG_PLANE_WIDTH:  width_q = v;
      default: ;
    endcase
    n_cfg++;
  endtask

  task automatic set_plane(int r, int h, int w);
    drain();
    cfg_set(REG_STAMP_RADIUS, 9'(r));
    cfg_set(REG_PLANE_HEIGHT, 9'(h));
    cfg_set(REG_PLANE_WIDTH, 9'(w));
  endtask

  task automatic run_random(int n, int span);
    for (int i = 0; i < n; i++) send_cmd(gen_cmd(span), 0, '0);
  endtask

  // result side: random pop, with a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 0;
    end else if (stall_done != stall_asks) begin
      stall_done <= stall_done + 1;
      hold <= STALL_LEN;
      pop <= 0;
    end else if (hold > 0) begin
      hold <= hold - 1;
      pop <= 0;
    end else if (eager || $urandom_range(0, 9) < 7) begin
      pop <= 1;
    end else begin
      pop <= 0;
      hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 2);
    end
  end

  always @(negedge clk) begin
    res_t e;
    if (rst_n && pop && !empty) begin
      if (pending_q.size() == 0) begin
        $error("result beat with nothing expected");
        errs++;
      end else begin
        e = pending_q.pop_front();
        if (out_added_count !== e.count) begin
          $error("added_count: expected %0d, got %0d", e.count, out_added_count);
          errs++;
        end
        if (out_pixel_fg !== e.fg) begin
          $error("pixel_fg: expected %0d, got %0d", e.fg, out_pixel_fg);
          errs++;
        end
        if (out_pixel_marked !== e.marked) begin
          $error("pixel_marked: expected %0d, got %0d", e.marked, out_pixel_marked);
          errs++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("thick_bezier_join_painter regression: fail");
      $finish;
    end
  end

  initial begin
    row_t tbl [$];
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // load every pixel a draw can reach: row 0, column 0 and a 20x20 corner
    for (int i = 0; i < PLANE_DIM; i++) begin
      for (int j = 0; j < PLANE_DIM; j++) begin
        if (i == 0 || j == 0 || (i < 20 && j < 20)) begin
          note_loaded(i, j);
          send_cmd(mk(OP_WRITE, i, j, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom_range(0, 3) & ($urandom_range(0, 3) ? 2 : 3)),
                   0, '0);
        end
      end
    end
    set_plane(1, 20, 20);

    note_loaded(5, 5);
    note_loaded(255, 255);
    tbl.push_back('{mk(OP_WRITE, 5, 5, 0, 0, 0, 0, 0, 0, 3), 1, rz(0, 0, 0)});
    tbl.push_back('{mk(OP_READ, 5, 5, 0, 0, 0, 0, 0, 0, 0), 1, rz(0, 1, 1)});
    tbl.push_back('{mk(OP_WRITE, 5, 5, 0, 0, 0, 0, 0, 0, 1), 1, rz(0, 0, 0)});
    tbl.push_back('{mk(OP_READ, 5, 5, 0, 0, 0, 0, 0, 0, 0), 1, rz(0, 1, 0)});
    tbl.push_back('{mk(OP_WRITE, 5, 5, 0, 0, 0, 0, 0, 0, 2), 1, rz(0, 0, 0)});
    tbl.push_back('{mk(OP_READ, 5, 5, 0, 0, 0, 0, 0, 0, 3), 1, rz(0, 0, 1)});
    tbl.push_back('{mk(OP_WRITE, 5, 5, 0, 0, 0, 0, 0, 0, 0), 1, rz(0, 0, 0)});
    tbl.push_back('{mk(OP_READ, 5, 5, 0, 0, 0, 0, 0, 0, 0), 1, rz(0, 0, 0)});
    tbl.push_back('{mk(OP_WRITE, 255, 255, -1, -1, 255, 255, -1, -1, 3), 1, rz(0, 0, 0)});
    tbl.push_back('{mk(OP_READ, 255, 255, 0, 0, 0, 0, 0, 0, 0), 1, rz(0, 1, 1)});
    tbl.push_back('{mk(OP_NOP, 255, 255, -1, -1, 255, 255, -1, -1, 3), 1, rz(0, 0, 0)});
    // coinciding endpoints paint nothing
    tbl.push_back('{mk(OP_DRAW, 7, 7, 16384, 0, 7, 7, 0, 16384, 0), 1, rz(0, 0, 0)});
    tbl.push_back('{mk(OP_DRAW, 2, 2, 16384, 0, 12, 15, 0, -16384, 0), 0, '0});
    tbl.push_back('{mk(OP_DRAW, 0, 0, 32767, -32768, 19, 19, -32768, 32767, 0), 0, '0});
    tbl.push_back('{mk(OP_DRAW, 255, 255, -16384, -16384, 0, 0, 16384, 16384, 0), 0, '0});
    tbl.push_back('{mk(OP_DRAW, 10, 0, 0, 0, 10, 19, 0, 0, 0), 0, '0});
    tbl.push_back('{mk(OP_READ, 10, 5, 0, 0, 0, 0, 0, 0, 0), 0, '0});
    tbl.push_back('{mk(OP_DRAW, 0, 19, 11585, -11585, 19, 0, -11585, 11585, 3), 0, '0});
    tbl.push_back('{mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0});
    foreach (tbl[i]) send_cmd(tbl[i].c, tbl[i].known, tbl[i].r);

    set_plane(0, 20, 20);
    eager = 1;
    stall_asks++;   // long hold on the result side while commands keep coming
    run_random(120, 27);
    eager = 0;

    set_plane(7, 0, 20);    // empty plane
    run_random(70, 27);
    set_plane(1, 511, 1);   // column 0 only, height clamps
    run_random(120, 255);
    set_plane(2, 1, 300);   // row 0 only, width clamps
    run_random(120, 255);
    set_plane(3, 20, 20);
    run_random(120, 27);
    for (int p = 0; p < 3; p++) begin
      set_plane($urandom_range(0, 7), $urandom_range(1, 20), $urandom_range(1, 20));
      run_random(110, 27);
    end

    drain();
    repeat (200) @(posedge clk);
    $display("covered %0d commands: %0d draws, %0d reads, %0d register writes,",
             n_cmds, n_draws, n_reads, n_cfg);
    $display("plane sizes from empty to clamped, radius 0 to 7, one long result stall");
    if (errs == 0 && pending_q.size() == 0)
      $display("thick_bezier_join_painter regression: pass");
    else
      $display("thick_bezier_join_painter regression: fail");
    $finish;
  end

endmodule

/* files.f */
src/tbjp_pkg.sv
src/tbjp_front.sv
src/tbjp_div.sv
src/tbjp_back.sv
src/thick_bezier_join_painter.sv
verif/tb_top.sv
